>>> hw/rtl/tlpt_pkg.sv
// package for the two-level page translate access core
// holds status codes, microcode step/op/condition codes and the control store
// no dependencies
package tlpt_pkg;

	// default size of the byte memory
	localparam int unsigned MEM_BYTES_DEF = 65536;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NO_DIR = 2'd1,
		ST_NO_TBL = 2'd2,
		ST_RANGE  = 2'd3
	} st_t;

	// configuration register index (address bit 2)
	localparam logic REG_PAGING = 1'b0;
	localparam logic REG_PDB    = 1'b1;

	// datapath micro-operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_DIR_EA,
		OP_ENTRY_RD,
		OP_TBL_EA,
		OP_PA,
		OP_NEXT,
		OP_CLR,
		OP_DATA,
		OP_DONE,
		OP_PHYS
	} uop_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_LEN_ZERO,
		C_NO_PAGING,
		C_EA_RANGE,
		C_ENTRY_RUN,
		C_NOT_PRESENT,
		C_SECOND,
		C_PA_RANGE,
		C_DATA_RUN
	} ucond_t;

	typedef logic [3:0] upc_t;

	// program step addresses
	localparam upc_t P_IDLE     = 4'd0;
	localparam upc_t P_LEN      = 4'd1;
	localparam upc_t P_MODE     = 4'd2;
	localparam upc_t P_DIR_EA   = 4'd3;
	localparam upc_t P_DIR_CHK  = 4'd4;
	localparam upc_t P_DIR_RD   = 4'd5;
	localparam upc_t P_DIR_PRES = 4'd6;
	localparam upc_t P_TBL_CHK  = 4'd7;
	localparam upc_t P_TBL_RD   = 4'd8;
	localparam upc_t P_TBL_PRES = 4'd9;
	localparam upc_t P_NEXT     = 4'd10;
	localparam upc_t P_RANGE    = 4'd11;
	localparam upc_t P_DATA     = 4'd12;
	localparam upc_t P_DONE     = 4'd13;
	localparam upc_t P_PHYS     = 4'd14;

	// one control word: op, jump condition, jump target, status load on jump
	typedef struct packed {
		uop_t   op;
		ucond_t cond;
		upc_t   target;
		logic   set_st;
		st_t    fst;
	} uword_t;

	// control store
	function automatic uword_t ucode_rom(upc_t pc);
		uword_t w;
		case (pc)
			P_IDLE:     w = '{OP_LATCH,    C_NO_START,    P_IDLE,     1'b0, ST_OK};
			P_LEN:      w = '{OP_NONE,     C_LEN_ZERO,    P_DONE,     1'b0, ST_OK};
			P_MODE:     w = '{OP_NONE,     C_NO_PAGING,   P_PHYS,     1'b0, ST_OK};
			P_DIR_EA:   w = '{OP_DIR_EA,   C_NEVER,       P_IDLE,     1'b0, ST_OK};
			P_DIR_CHK:  w = '{OP_NONE,     C_EA_RANGE,    P_DONE,     1'b1, ST_RANGE};
			P_DIR_RD:   w = '{OP_ENTRY_RD, C_ENTRY_RUN,   P_DIR_RD,   1'b0, ST_OK};
			P_DIR_PRES: w = '{OP_TBL_EA,   C_NOT_PRESENT, P_DONE,     1'b1, ST_NO_DIR};
			P_TBL_CHK:  w = '{OP_NONE,     C_EA_RANGE,    P_DONE,     1'b1, ST_RANGE};
			P_TBL_RD:   w = '{OP_ENTRY_RD, C_ENTRY_RUN,   P_TBL_RD,   1'b0, ST_OK};
			P_TBL_PRES: w = '{OP_PA,       C_NOT_PRESENT, P_DONE,     1'b1, ST_NO_TBL};
			P_NEXT:     w = '{OP_NEXT,     C_SECOND,      P_DIR_EA,   1'b0, ST_OK};
			P_RANGE:    w = '{OP_CLR,      C_PA_RANGE,    P_DONE,     1'b1, ST_RANGE};
			P_DATA:     w = '{OP_DATA,     C_DATA_RUN,    P_DATA,     1'b0, ST_OK};
			P_DONE:     w = '{OP_DONE,     C_ALWAYS,      P_IDLE,     1'b0, ST_OK};
			P_PHYS:     w = '{OP_PHYS,     C_ALWAYS,      P_RANGE,    1'b0, ST_OK};
			default:    w = '{OP_NONE,     C_ALWAYS,      P_IDLE,     1'b0, ST_OK};
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/tlpt_mem.sv
// byte-wide single-port memory with registered read data
// holds the page tables and data; uses no package items
module tlpt_mem #(
	parameter int unsigned MEM_BYTES = 65536,
	parameter int unsigned AW        = $clog2(MEM_BYTES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [MEM_BYTES];

	// write and registered read at one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hw/rtl/two_level_page_translate_access_core.sv
// top level of the two-level page translate access core
// microcoded sequencer over a byte memory; uses tlpt_pkg and tlpt_mem
//
//  port group  | direction | handshake
//  ------------+-----------+-----------------------------------------------
//  command     | in        | start, busy: taken when start && !busy
//  result      | out       | done: one-cycle strobe, receiver cannot stall
//  config      | in/out    | apb psel/penable/pwrite/paddr/pwdata/prdata
//
// one word at a time; busy from the accepting edge until the done cycle ends.
// with paging on, each page touched costs a directory entry read and a table entry read
// over the byte-serial memory port before the data bytes move; with paging off only the
// data bytes move. a fault ends the program early; a zero length goes straight to done.
// arst_n clears the sequencer and registers; memory contents are not cleared.
module two_level_page_translate_access_core
	import tlpt_pkg::*;
#(
	parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [31:0] virtual_address,
	input  logic [2:0]  access_length,
	input  logic [31:0] write_data,
	// result
	output logic        done,
	output logic [31:0] read_data,
	output logic [1:0]  status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW = $clog2(MEM_BYTES);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	// configuration registers
	logic        paging_q;
	logic [31:0] pdb_q;

	// sequencer and datapath registers
	upc_t        pc_q;
	logic        func_q;
	logic [31:0] va_q;
	logic [2:0]  len_q;
	logic [2:0]  n1_q;
	logic [31:0] wd_q;
	logic        part_q;
	logic [31:0] ea_q;
	logic [31:0] entry_q;
	logic [31:0] pa1_q;
	logic [31:0] pa2_q;
	logic [2:0]  cnt_q;
	logic [31:0] rd_q;
	st_t         st_q;

	uword_t      uw;
	logic        take;
	logic [2:0]  len_c;
	logic [12:0] rem;
	logic [2:0]  n1_c;
	logic [2:0]  n2;
	logic [31:0] va2;
	logic [31:0] va_cur;
	logic        ea_over;
	logic        pa_over;
	logic [1:0]  bsel;
	logic        mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]  mem_rdata;
	logic        in_first;

	// apb register file
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PDB) ? pdb_q : {31'b0, paging_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			pdb_q    <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_PDB) begin
				pdb_q <= pwdata;
			end else begin
				paging_q <= pwdata[0];
			end
		end
	end

	// current control word and handshake outputs
	assign uw        = ucode_rom(pc_q);
	assign busy      = (pc_q != P_IDLE);
	assign done      = (uw.op == OP_DONE);
	assign read_data = rd_q;
	assign status    = st_q;

	// command decode: clamp length, split at the page boundary
	assign len_c = (access_length > 3'd4) ? 3'd4 : access_length;
	assign rem   = 13'h1000 - {1'b0, virtual_address[11:0]};
	assign n1_c  = (rem < {10'b0, len_c}) ? rem[2:0] : len_c;
	assign n2    = len_q - n1_q;
	assign va2   = va_q + {29'b0, n1_q};
	assign va_cur = part_q ? va2 : va_q;

	// range checks
	assign ea_over = ({1'b0, ea_q} + 33'd4) > MEM_LIMIT;
	assign pa_over = (({1'b0, pa1_q} + {30'b0, n1_q}) > MEM_LIMIT) ||
		((n2 != 3'd0) && (({1'b0, pa2_q} + {30'b0, n2}) > MEM_LIMIT));

	// jump condition select
	always_comb begin
		case (uw.cond)
			C_NEVER:       take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_START:    take = !start;
			C_LEN_ZERO:    take = (len_q == 3'd0);
			C_NO_PAGING:   take = !paging_q;
			C_EA_RANGE:    take = ea_over;
			C_ENTRY_RUN:   take = (cnt_q != 3'd4);
			C_NOT_PRESENT: take = !entry_q[0];
			C_SECOND:      take = !part_q && (n2 != 3'd0);
			C_PA_RANGE:    take = pa_over;
			C_DATA_RUN:    take = (cnt_q != len_q);
			default:       take = 1'b0;
		endcase
	end

	// memory address and write enable
	assign in_first = (cnt_q < n1_q);
	assign bsel     = 2'(cnt_q - 3'd1);
	assign mem_we   = (uw.op == OP_DATA) && func_q && (cnt_q < len_q);

	always_comb begin
		if (uw.op == OP_DATA) begin
			if (in_first) begin
				mem_addr = AW'(pa1_q + {29'b0, cnt_q});
			end else begin
				mem_addr = AW'(pa2_q + {29'b0, 3'(cnt_q - n1_q)});
			end
		end else begin
			mem_addr = AW'(ea_q + {29'b0, cnt_q});
		end
	end

	tlpt_mem #(
		.MEM_BYTES(MEM_BYTES),
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(wd_q[{cnt_q[1:0], 3'b000} +: 8]),
		.rdata(mem_rdata)
	);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= upc_t'(pc_q + 4'd1);
		end
	end

	// control state of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_OK;
			cnt_q  <= '0;
			part_q <= 1'b0;
			rd_q   <= '0;
		end else begin
			if (take && uw.set_st) begin
				st_q <= uw.fst;
			end
			case (uw.op)
				OP_LATCH: begin
					if (start) begin
						st_q   <= ST_OK;
						cnt_q  <= '0;
						part_q <= 1'b0;
						rd_q   <= '0;
					end
				end
				OP_DIR_EA, OP_TBL_EA, OP_CLR: begin
					cnt_q <= '0;
				end
				OP_ENTRY_RD: begin
					if (cnt_q != 3'd4) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				OP_NEXT: begin
					part_q <= 1'b1;
				end
				OP_DATA: begin
					if (cnt_q != 3'd0 && !func_q) begin
						rd_q[{bsel, 3'b000} +: 8] <= mem_rdata;
					end
					if (cnt_q != len_q) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the datapath
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LATCH: begin
				if (start) begin
					func_q <= func;
					va_q   <= virtual_address;
					len_q  <= len_c;
					n1_q   <= n1_c;
					wd_q   <= write_data;
				end
			end
			OP_DIR_EA: begin
				ea_q <= pdb_q + {20'b0, va_cur[31:22], 2'b00};
			end
			OP_TBL_EA: begin
				ea_q <= {entry_q[31:12], 12'b0} + {20'b0, va_cur[21:12], 2'b00};
			end
			OP_ENTRY_RD: begin
				if (cnt_q != 3'd0) begin
					entry_q[{bsel, 3'b000} +: 8] <= mem_rdata;
				end
			end
			OP_PA: begin
				if (part_q) begin
					pa2_q <= {entry_q[31:12], va_cur[11:0]};
				end else begin
					pa1_q <= {entry_q[31:12], va_cur[11:0]};
				end
			end
			OP_PHYS: begin
				pa1_q <= va_q;
				pa2_q <= va2;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer not idle after result");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (st_q != ST_OK)) |-> (rd_q == 32'd0))
		else $error("faulting result carries read data");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (st_q == ST_OK && !pa_over))
		else $error("memory written after a fault");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (cnt_q <= 3'd4))
		else $error("byte counter out of range");
`endif

endmodule
